>>> src/bayer_dither_window_pixel_writer_defines.svh
// Assertion macros shared by the pixel writer RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef BAYER_DITHER_WINDOW_PIXEL_WRITER_DEFINES_SVH
`define BAYER_DITHER_WINDOW_PIXEL_WRITER_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define BDW_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define BDW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bdw_pkg.sv
// Shared types, constants and the Bayer threshold table of the pixel writer.
// No dependencies; used by bdw_dither and bayer_dither_window_pixel_writer.
package bdw_pkg;

  // Panel limits
  localparam int unsigned MAX_WIDTH = 2048;
  localparam int unsigned MAX_ROWS  = 4096;

  // Field and register widths
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned X_W        = 11;
  localparam int unsigned Y_W        = 12;
  localparam int unsigned PW_W       = 12;
  localparam int unsigned ADDR_W     = 20;
  localparam int unsigned BIDX_W     = 3;
  localparam int unsigned STRIDE_W   = $clog2(MAX_WIDTH / 8 + 1);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Register reset values
  localparam logic [PW_W-1:0] LINE_DOTS_RST   = 12'd384;
  localparam logic [X_W-1:0]  WIN_X_START_RST = 11'd0;
  localparam logic [X_W-1:0]  WIN_X_END_RST   = 11'd383;
  localparam logic [Y_W-1:0]  WIN_Y_START_RST = 12'd0;
  localparam logic [Y_W-1:0]  WIN_Y_END_RST   = 12'd0;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_DOTS   = 3'd0,
    REG_WIN_X_START = 3'd1,
    REG_WIN_X_END   = 3'd2,
    REG_WIN_Y_START = 3'd3,
    REG_WIN_Y_END   = 3'd4
  } cfg_reg_e;

  // Scan position inside the window
  typedef struct packed {
    logic [Y_W-1:0] y;
    logic [X_W-1:0] x;
  } pos_t;

  // One frame-buffer bit write
  typedef struct packed {
    logic              bit_value;
    logic [BIDX_W-1:0] bit_index;
    logic [ADDR_W-1:0] byte_address;
  } result_t;

  // 4x4 Bayer thresholds, index is {y[1:0], x[1:0]}
  function automatic logic [7:0] dither_thr(input logic [3:0] idx);
    logic [7:0] thr;
    case (idx)
      4'd0:    thr = 8'd8;
      4'd1:    thr = 8'd200;
      4'd2:    thr = 8'd40;
      4'd3:    thr = 8'd232;
      4'd4:    thr = 8'd72;
      4'd5:    thr = 8'd136;
      4'd6:    thr = 8'd104;
      4'd7:    thr = 8'd168;
      4'd8:    thr = 8'd56;
      4'd9:    thr = 8'd248;
      4'd10:   thr = 8'd24;
      4'd11:   thr = 8'd216;
      4'd12:   thr = 8'd120;
      4'd13:   thr = 8'd184;
      4'd14:   thr = 8'd88;
      4'd15:   thr = 8'd152;
      default: thr = 8'd0;
    endcase
    return thr;
  endfunction

endpackage

>>> src/bdw_dither.sv
// Per-pixel datapath: RGB565 to luma, Bayer threshold and frame-buffer address.
// Depends on bdw_pkg.
module bdw_dither (
  input  logic [bdw_pkg::PIX_W-1:0] pixel_i,
  input  bdw_pkg::pos_t             pos_i,
  input  logic [bdw_pkg::PW_W-1:0]  line_dots_i,
  output bdw_pkg::result_t          result_o
);

  localparam int unsigned PROD_W = bdw_pkg::STRIDE_W + bdw_pkg::Y_W;

  logic [4:0]                  r5, b5;
  logic [5:0]                  g6;
  logic [7:0]                  r8, g8, b8;
  logic [9:0]                  luma_sum;
  logic [7:0]                  luma;
  logic [7:0]                  thr;
  logic [8:0]                  dith_sum;
  logic [bdw_pkg::PW_W-1:0]    pw_lim;
  logic [bdw_pkg::PW_W:0]      pw_round;
  logic [bdw_pkg::STRIDE_W-1:0] stride_bytes;
  logic [PROD_W-1:0]           row_base;
  logic [PROD_W-1:0]           addr_full;

  // Expand channels by bit replication and form (R + 2G + B) / 4
  assign r5       = pixel_i[15:11];
  assign g6       = pixel_i[10:5];
  assign b5       = pixel_i[4:0];
  assign r8       = {r5, r5[4:2]};
  assign g8       = {g6, g6[5:4]};
  assign b8       = {b5, b5[4:2]};
  assign luma_sum = {2'b00, r8} + {1'b0, g8, 1'b0} + {2'b00, b8};
  assign luma     = luma_sum[9:2];

  // Threshold against the Bayer cell of this position
  assign thr      = bdw_pkg::dither_thr({pos_i.y[1:0], pos_i.x[1:0]});
  assign dith_sum = {1'b0, luma} + {1'b0, thr};

  // Row stride in bytes: width limited to the panel maximum, rounded up to 8
  assign pw_lim       = (line_dots_i > bdw_pkg::PW_W'(bdw_pkg::MAX_WIDTH)) ?
                        bdw_pkg::PW_W'(bdw_pkg::MAX_WIDTH) : line_dots_i;
  assign pw_round     = {1'b0, pw_lim} + (bdw_pkg::PW_W + 1)'(7);
  assign stride_bytes = bdw_pkg::STRIDE_W'(pw_round[bdw_pkg::PW_W:3]);

  // Byte address = stride * y + x / 8; the bit index is x mod 8
  assign row_base  = PROD_W'(stride_bytes) * PROD_W'(pos_i.y);
  assign addr_full = row_base + PROD_W'(pos_i.x[bdw_pkg::X_W-1:3]);

  assign result_o.byte_address = bdw_pkg::ADDR_W'(addr_full);
  assign result_o.bit_index    = pos_i.x[bdw_pkg::BIDX_W-1:0];
  assign result_o.bit_value    = dith_sum[8];

endmodule

>>> src/bayer_dither_window_pixel_writer.sv
// Top level of the ordered-dither 1bpp pixel writer.
// Depends on bdw_pkg, bdw_dither and bayer_dither_window_pixel_writer_defines.svh.
//
// Usage:
//   s_axis carries one RGB565 pixel per word (tdata[15:0]). m_axis returns one
//   frame-buffer bit write per pixel: tdata holds byte address, MSB-first bit
//   index and dithered bit; tlast marks the last pixel of the window.
//   The cfg channel writes line width (0), win_x_start (1), win_x_end (2),
//   win_y_start (3) and win_y_end (4); it is always ready. Any window write
//   reloads the scan position to the window start. Write only while idle.
//   An accepted pixel reaches m_axis through the input register, then the
//   result register. Throughput: one pixel per clock while m_axis_tready is
//   high, set by this two-register pipeline around a combinational datapath.
//   Reset: registers take 384 / 0 / 383 / 0 / 0, position is (0, 0), both
//   pipeline registers empty.
//   Stall: while m_axis_tready is low the result word holds; the input
//   register still takes one pixel if it is empty, then s_axis_tready drops
//   until the receiver takes the held word.
`include "bayer_dither_window_pixel_writer_defines.svh"

module bayer_dither_window_pixel_writer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel input; tdata: pixel_rgb565[15:0]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bdw_pkg::PIX_W-1:0]       s_axis_tdata,
  // bit writes; tdata: byte_address[19:0], bit_index[22:20], bit_value[23]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,
  output logic                            m_axis_tlast,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bdw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bdw_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned X_W = bdw_pkg::X_W;
  localparam int unsigned Y_W = bdw_pkg::Y_W;

  // Configuration registers
  logic [bdw_pkg::PW_W-1:0] line_dots_q, line_dots_d;
  logic [X_W-1:0]           win_x_start_q, win_x_start_d;
  logic [X_W-1:0]           win_x_end_q, win_x_end_d;
  logic [Y_W-1:0]           win_y_start_q, win_y_start_d;
  logic [Y_W-1:0]           win_y_end_q, win_y_end_d;
  logic                     cfg_we;
  logic                     reload;

  // Scan position
  bdw_pkg::pos_t            pos_q, pos_d;
  logic [X_W-1:0]           x_end_eff;
  logic [Y_W-1:0]           y_end_eff;
  logic [X_W:0]             nx;
  logic [Y_W:0]             ny;
  logic                     col_wrap;
  logic                     row_wrap;

  // Pipeline
  logic                     s_accept;
  logic                     s1_valid_q, s1_valid_d;
  logic [bdw_pkg::PIX_W-1:0] s1_pix_q;
  bdw_pkg::pos_t            s1_pos_q;
  logic                     s1_last_q;
  logic                     s1_ready;
  logic                     out_valid_q, out_valid_d;
  bdw_pkg::result_t         out_res_q;
  logic                     out_last_q;
  logic                     out_ready;
  bdw_pkg::result_t         res;

  // Accept configuration writes at any time
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Decode register writes
  always_comb begin
    line_dots_d   = line_dots_q;
    win_x_start_d = win_x_start_q;
    win_x_end_d   = win_x_end_q;
    win_y_start_d = win_y_start_q;
    win_y_end_d   = win_y_end_q;
    reload        = 1'b0;
    if (cfg_we) begin
      case (bdw_pkg::cfg_reg_e'(cfg_index_i))
        bdw_pkg::REG_LINE_DOTS:   line_dots_d   = cfg_data_i[bdw_pkg::PW_W-1:0];
        bdw_pkg::REG_WIN_X_START: win_x_start_d = cfg_data_i[X_W-1:0];
        bdw_pkg::REG_WIN_X_END:   win_x_end_d   = cfg_data_i[X_W-1:0];
        bdw_pkg::REG_WIN_Y_START: win_y_start_d = cfg_data_i[Y_W-1:0];
        bdw_pkg::REG_WIN_Y_END:   win_y_end_d   = cfg_data_i[Y_W-1:0];
        default: ;
      endcase
      reload = cfg_index_i inside {bdw_pkg::REG_WIN_X_START, bdw_pkg::REG_WIN_X_END,
                                   bdw_pkg::REG_WIN_Y_START, bdw_pkg::REG_WIN_Y_END};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_dots_q   <= bdw_pkg::LINE_DOTS_RST;
      win_x_start_q <= bdw_pkg::WIN_X_START_RST;
      win_x_end_q   <= bdw_pkg::WIN_X_END_RST;
      win_y_start_q <= bdw_pkg::WIN_Y_START_RST;
      win_y_end_q   <= bdw_pkg::WIN_Y_END_RST;
    end else begin
      line_dots_q   <= line_dots_d;
      win_x_start_q <= win_x_start_d;
      win_x_end_q   <= win_x_end_d;
      win_y_start_q <= win_y_start_d;
      win_y_end_q   <= win_y_end_d;
    end
  end

  // Limit window ends to the panel maximum
  assign x_end_eff = (win_x_end_q > X_W'(bdw_pkg::MAX_WIDTH - 1)) ?
                     X_W'(bdw_pkg::MAX_WIDTH - 1) : win_x_end_q;
  assign y_end_eff = (win_y_end_q > Y_W'(bdw_pkg::MAX_ROWS - 1)) ?
                     Y_W'(bdw_pkg::MAX_ROWS - 1) : win_y_end_q;

  // Detect column and row wrap
  assign nx       = {1'b0, pos_q.x} + (X_W + 1)'(1);
  assign ny       = {1'b0, pos_q.y} + (Y_W + 1)'(1);
  assign col_wrap = nx > {1'b0, x_end_eff};
  assign row_wrap = col_wrap && (ny > {1'b0, y_end_eff});

  // Advance the position on each accepted pixel, reload on window writes
  always_comb begin
    pos_d = pos_q;
    if (reload) begin
      pos_d.x = win_x_start_q;
      pos_d.y = win_y_start_q;
      if (bdw_pkg::cfg_reg_e'(cfg_index_i) == bdw_pkg::REG_WIN_X_START) begin
        pos_d.x = win_x_start_d;
      end
      if (bdw_pkg::cfg_reg_e'(cfg_index_i) == bdw_pkg::REG_WIN_Y_START) begin
        pos_d.y = win_y_start_d;
      end
    end else if (s_accept) begin
      if (col_wrap) begin
        pos_d.x = win_x_start_q;
        pos_d.y = row_wrap ? win_y_start_q : ny[Y_W-1:0];
      end else begin
        pos_d.x = nx[X_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q.x <= bdw_pkg::WIN_X_START_RST;
      pos_q.y <= bdw_pkg::WIN_Y_START_RST;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Pipeline handshake: each stage loads when it is empty or the stage after it drains
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || out_ready;
  assign s_axis_tready = s1_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_ready) begin
      s1_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register: pixel, its position and the wrap flag
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_pix_q  <= s_axis_tdata;
      s1_pos_q  <= pos_q;
      s1_last_q <= row_wrap;
    end
  end

  bdw_dither u_dither (
    .pixel_i     (s1_pix_q),
    .pos_i       (s1_pos_q),
    .line_dots_i (line_dots_q),
    .result_o    (res)
  );

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_res_q  <= res;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.bit_value, out_res_q.bit_index, out_res_q.byte_address};
  assign m_axis_tlast  = out_last_q;

  // Assertions
  `BDW_ASSERT_NEXT(a_wrap_reload, clk_i, rst_ni, s_accept && row_wrap,
    pos_q.x == win_x_start_q && pos_q.y == win_y_start_q, "position not at window start")
  `BDW_ASSERT_NEXT(a_col_step, clk_i, rst_ni, s_accept && !col_wrap && !cfg_we,
    pos_q.x == $past(nx[X_W-1:0]), "column did not advance by one")
  `BDW_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s1_ready,
    s1_valid_q, "input register dropped a pixel")
  `BDW_ASSERT_IMPL(a_full_stall, clk_i, rst_ni, s1_valid_q && out_valid_q && !m_axis_tready,
    !s_axis_tready, "pixel taken while pipeline full")

endmodule
